// ----- design/erxaf_pkg.sv -----
// Shared types and constants for the Ethernet receive address filter.
package erxaf_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = 48;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};

  // item kinds
  localparam logic [1:0] KIND_CHECK = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;

  // match kinds
  localparam logic [2:0] MK_OWN_SRC = 3'd0;
  localparam logic [2:0] MK_OWN_DST = 3'd1;
  localparam logic [2:0] MK_BCAST   = 3'd2;
  localparam logic [2:0] MK_MCAST   = 3'd3;
  localparam logic [2:0] MK_NONE    = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] target_addr;
    logic [ADDR_W-1:0] source_addr;
  } in_beat_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] match_kind;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_req_t;

endpackage

// ----- design/erxaf_mem.sv -----
// Multicast address table: one write port, one registered read port.
module erxaf_mem (
  input  logic                      clk,
  input  erxaf_pkg::mem_req_t       req,
  output logic [erxaf_pkg::ADDR_W-1:0] rd_data
);
  import erxaf_pkg::*;

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/ethernet_rx_address_filter.sv -----
// Top level of the Ethernet receive address filter with multicast table.
//
// Usage:
//   in_*  : one beat per item (check frame, add address, delete address).
//   out_* : one result beat per item, in order.
//   cfg_* : writes the 48-bit station address; always ready, write only
//           while the block is idle.
// One item is worked on at a time; in_ready is high only when idle.
// Path from input beat to output valid:
//   - frame decided by station/broadcast compare, add, unused kind: decode, emit.
//   - multicast lookup or delete: decode, then a walk of up to TABLE_DEPTH entries,
//     sequential over the table memory, one entry read per cycle through its
//     single read port (a hit ends the walk early), then emit.
// The next beat can be taken in the cycle after the result is loaded.
// Result goes into an output register, so the next item can be taken while
// a result waits; a stalled receiver holds the waiting result plus at most
// one finished item, and in_ready stays low until the register frees up.
// Reset clears the valid bits of all table slots (flip-flops, at once), the
// station address and all handshake state; no clearing pass is needed.
module ethernet_rx_address_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  erxaf_pkg::in_beat_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output erxaf_pkg::out_beat_t           out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [erxaf_pkg::ADDR_W-1:0]   cfg_data
);
  import erxaf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  in_beat_t               item_r, item_nxt;
  logic [ADDR_W-1:0]      station_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       issue_cnt_r, issue_cnt_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  out_beat_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_beat_t              out_r, out_nxt;

  mem_req_t               mem_req;
  logic [ADDR_W-1:0]      rd_data;

  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   issue;
  logic                   hit;

  erxaf_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign issue = (state_r == S_SCAN) && (issue_cnt_r < CNT_W'(TABLE_DEPTH));
  // read data of cmp_idx_r arrives this cycle
  assign hit   = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data == item_r.target_addr);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    valid_nxt     = valid_r;
    issue_cnt_nxt = issue_cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    mem_req         = '0;
    mem_req.wr_addr = free_idx;
    mem_req.wr_data = item_r.target_addr;
    mem_req.rd_addr = issue_cnt_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        issue_cnt_nxt = '0;
        res_nxt       = '{accept: 1'b0, match_kind: MK_NONE, status: STAT_DONE};
        state_nxt     = S_EMIT;
        case (item_r.kind)
          KIND_CHECK: begin
            if (item_r.source_addr == station_r) begin
              res_nxt.match_kind = MK_OWN_SRC;
            end else if (item_r.target_addr == station_r) begin
              res_nxt = '{accept: 1'b1, match_kind: MK_OWN_DST, status: STAT_DONE};
            end else if (item_r.target_addr == BCAST_ADDR) begin
              res_nxt = '{accept: 1'b1, match_kind: MK_BCAST, status: STAT_DONE};
            end else begin
              state_nxt = S_SCAN;
            end
          end
          KIND_ADD: begin
            if (free_found) begin
              mem_req.wr_en       = 1'b1;
              valid_nxt[free_idx] = 1'b1;
            end else begin
              res_nxt.status = STAT_FULL;
            end
          end
          KIND_DEL: begin
            state_nxt = S_SCAN;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        mem_req.rd_en = issue;
        issue_cnt_nxt = issue_cnt_r + CNT_W'(issue);
        cmp_vld_nxt   = issue;
        cmp_idx_nxt   = issue_cnt_r[IDX_W-1:0];
        if (hit) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
          if (item_r.kind == KIND_DEL) begin
            valid_nxt[cmp_idx_r] = 1'b0;
            res_nxt = '{accept: 1'b0, match_kind: MK_NONE, status: STAT_DONE};
          end else begin
            res_nxt = '{accept: 1'b1, match_kind: MK_MCAST, status: STAT_DONE};
          end
        end else if (cmp_vld_r && (cmp_idx_r == IDX_W'(TABLE_DEPTH - 1))) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
          if (item_r.kind == KIND_DEL) begin
            res_nxt = '{accept: 1'b0, match_kind: MK_NONE, status: STAT_ABSENT};
          end else begin
            res_nxt = '{accept: 1'b0, match_kind: MK_NONE, status: STAT_DONE};
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      station_r   <= '0;
      issue_cnt_r <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        station_r <= cfg_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // compare slot only live during the table walk
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == S_SCAN))
    else $error("compare valid outside table walk");

  // successful add marks its slot in use
  a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && item_r.kind == KIND_ADD && free_found)
      |=> valid_r[$past(free_idx)])
    else $error("add did not set slot valid");

  // a delete hit frees exactly one slot
  a_del_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit && item_r.kind == KIND_DEL)
      |=> ($countones(valid_r) == $past($countones(valid_r)) - 1))
    else $error("delete freed other than one slot");

  // slot bits only move while an item is being worked on
  a_valid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_EMIT) |=> $stable(valid_r))
    else $error("slot valid changed while idle");

  // a new result beat comes only from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) && state_r != S_EMIT |=> !out_valid_r)
    else $error("result beat without emit");
`endif

endmodule

// ----- bench/tb_ethernet_rx_address_filter.sv -----
// Self-checking bench for the Ethernet receive address filter.
module tb_ethernet_rx_address_filter;
  import erxaf_pkg::*;

  // Item kind 3 has no meaning in the block; it must come back as a plain "done".
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int POOL_SIZE      = 8;     // multicast addresses reused for hits and duplicates
  localparam int STALL_CYCLES   = 60;    // long receiver hold-off, well past one-item buffering
  localparam int SETTLE_CYCLES  = 25;    // covers the longest item, a full table walk
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat before giving up
  localparam int PHASE_ITEMS    = 100;   // counted items per random phase, four phases

  localparam logic [ADDR_W-1:0] STATION_A = 48'h02_1A_2B_3C_4D_5E;
  localparam logic [ADDR_W-1:0] MCAST_A   = 48'h01_00_5E_00_00_01;
  localparam logic [ADDR_W-1:0] OTHER_A   = 48'h12_34_56_78_9A_BC;

  // Predicts the verdict of every accepted item and holds the verdicts not yet seen.
  class filter_verdicts;
    logic [ADDR_W-1:0] station;
    logic [ADDR_W-1:0] mc_addr [TABLE_DEPTH];
    bit                slot_used [TABLE_DEPTH];
    out_beat_t         pending_verdicts [$];
    int                errors;

    function new();
      station = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // lowest live slot holding the address, -1 if none
    function int lookup(logic [ADDR_W-1:0] a);
      int hit;
      hit = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        if (slot_used[i] && mc_addr[i] == a) hit = i;
      return hit;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (slot_used[i]) n += slot_used[i];
      return n;
    endfunction

    function void note_item(in_beat_t b);
      out_beat_t v;
      int        slot;
      v.accept     = 1'b0;
      v.match_kind = MK_NONE;
      v.status     = STAT_DONE;
      slot         = -1;
      case (b.kind)
        KIND_CHECK: begin
          // first test that holds decides
          if (b.source_addr == station) begin
            v.match_kind = MK_OWN_SRC;
          end else if (b.target_addr == station) begin
            v.accept = 1'b1; v.match_kind = MK_OWN_DST;
          end else if (b.target_addr == BCAST_ADDR) begin
            v.accept = 1'b1; v.match_kind = MK_BCAST;
          end else if (lookup(b.target_addr) >= 0) begin
            v.accept = 1'b1; v.match_kind = MK_MCAST;
          end
        end
        KIND_ADD: begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
          if (slot < 0) begin
            v.status = STAT_FULL;
          end else begin
            mc_addr[slot]   = b.target_addr;
            slot_used[slot] = 1'b1;
          end
        end
        KIND_DEL: begin
          slot = lookup(b.target_addr);
          if (slot < 0) v.status = STAT_ABSENT;
          else slot_used[slot] = 1'b0;
        end
        default: ;
      endcase
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(out_beat_t got);
      out_beat_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.accept !== want.accept) begin
          $error("accept: expected %0d, actual %0d", want.accept, got.accept);
          errors++;
        end
        if (got.match_kind !== want.match_kind) begin
          $error("match_kind: expected %0d, actual %0d", want.match_kind, got.match_kind);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
      end
    endfunction
  endclass

  // Every input driven to a known value from time zero.
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_beat_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_beat_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data  = '0;

  filter_verdicts    verdicts = new();
  logic [ADDR_W-1:0] mc_pool [POOL_SIZE];
  int                items_sent = 0;    // beats sent, ignored kind not counted
  bit                quiet      = 1'b0; // both sides stop idling while set
  bit                stall_req  = 1'b0; // asks the receiver for one long hold-off

  always #1 clk = ~clk;

  ethernet_rx_address_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Monitor: everything sampled on the rising edge, drivers move on the falling one.
  // Result is checked before the new beat is noted; a result never belongs to
  // a beat taken in the same cycle, since each beat goes through decode and emit.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) verdicts.check_verdict(out_data);
      if (cfg_valid && cfg_ready) verdicts.station = cfg_data;
      if (in_valid && in_ready) verdicts.note_item(in_data);
    end
  end

  // Receiver: ready low about 22% of cycles, never while quiet.
  // On request it holds ready low, so results back up into the block.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_req = 1'b0;
      end
      out_ready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: only cycles with no beat on any channel count.
  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // Mostly pool addresses so that table hits, duplicates and real deletes are common.
  function automatic logic [ADDR_W-1:0] pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 50) return mc_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 62) return verdicts.station;
    if (r < 72) return BCAST_ADDR;
    return rand_addr();
  endfunction

  function automatic logic [ADDR_W-1:0] pick_source();
    if ($urandom_range(99) < 15) return verdicts.station;
    return rand_addr();
  endfunction

  function automatic in_beat_t make_item(logic [1:0] k, logic [ADDR_W-1:0] t,
                                         logic [ADDR_W-1:0] s);
    in_beat_t b;
    b.kind        = k;
    b.target_addr = t;
    b.source_addr = s;
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // in_valid stays high into the next item unless a random gap lowers it.
  task automatic send_item(input in_beat_t b);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.kind != KIND_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until every verdict is back; the block is then idle since
  // every item gives exactly one result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_station(input logic [ADDR_W-1:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Adds pool addresses until no slot is free, then overflows once or twice.
  task automatic fill_table();
    while (verdicts.used_slots() < TABLE_DEPTH)
      send_item(make_item(KIND_ADD, mc_pool[$urandom_range(POOL_SIZE - 1)], rand_addr()));
    repeat ($urandom_range(2, 1))
      send_item(make_item(KIND_ADD, mc_pool[$urandom_range(POOL_SIZE - 1)], rand_addr()));
  endtask

  // Random part: bursts of frame checks, fills, deletes, plus raw noise.
  task automatic run_random(input int n);
    int goal;
    int pick;
    int len;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      len  = $urandom_range(10, 3);
      if (pick < 45) begin
        repeat (len) send_item(make_item(KIND_CHECK, pick_target(), pick_source()));
      end else if (pick < 60) begin
        fill_table();
      end else if (pick < 82) begin
        repeat (len) send_item(make_item(KIND_DEL, pick_target(), rand_addr()));
      end else if (pick < 94) begin
        repeat (len) send_item(make_item(2'($urandom_range(2)), rand_addr(), rand_addr()));
      end else begin
        repeat ($urandom_range(3, 1))
          send_item(make_item(KIND_UNUSED, rand_addr(), rand_addr()));
      end
    end
  endtask

  initial begin
    foreach (mc_pool[i]) mc_pool[i] = rand_addr() | 48'h01_00_00_00_00_00;

    // Synchronous reset, held low from time zero, then released for good.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: priority order of the frame tests, duplicates, absent deletes,
    // the ignored kind and field extremes.
    write_station(STATION_A);
    send_item(make_item(KIND_CHECK, BCAST_ADDR, STATION_A));   // own source beats broadcast
    send_item(make_item(KIND_CHECK, STATION_A, OTHER_A));      // own destination
    send_item(make_item(KIND_CHECK, BCAST_ADDR, '0));          // broadcast
    send_item(make_item(KIND_CHECK, '0, BCAST_ADDR));          // no match
    send_item(make_item(KIND_DEL, MCAST_A, '0));               // delete on empty table
    send_item(make_item(KIND_UNUSED, BCAST_ADDR, BCAST_ADDR)); // ignored
    send_item(make_item(KIND_ADD, MCAST_A, '0));
    send_item(make_item(KIND_ADD, MCAST_A, BCAST_ADDR));       // duplicate slot
    send_item(make_item(KIND_CHECK, MCAST_A, OTHER_A));        // table hit
    send_item(make_item(KIND_DEL, MCAST_A, '0));               // lowest duplicate goes
    send_item(make_item(KIND_CHECK, MCAST_A, OTHER_A));        // other copy still hits
    send_item(make_item(KIND_DEL, MCAST_A, '0));
    send_item(make_item(KIND_CHECK, MCAST_A, OTHER_A));        // now a miss
    send_item(make_item(KIND_DEL, MCAST_A, '0));               // absent
    send_item(make_item(KIND_ADD, BCAST_ADDR, '0));
    send_item(make_item(KIND_CHECK, BCAST_ADDR, OTHER_A));     // broadcast beats table
    send_item(make_item(KIND_ADD, STATION_A, '0));
    send_item(make_item(KIND_CHECK, STATION_A, OTHER_A));      // own dest beats table
    send_item(make_item(KIND_DEL, BCAST_ADDR, '0));
    send_item(make_item(KIND_DEL, STATION_A, '0));

    // Phase 1: random station, full table straight away, then a receiver
    // hold-off while the sender keeps offering frames.
    wait_drained();
    write_station(rand_addr());
    fill_table();
    stall_req = 1'b1;
    repeat (10) send_item(make_item(KIND_CHECK, pick_target(), pick_source()));
    run_random(PHASE_ITEMS);

    // Phase 2: station at all ones, so broadcast frames count as own.
    wait_drained();
    write_station(BCAST_ADDR);
    run_random(PHASE_ITEMS);

    // Phase 3: station zero, with no idling on either side.
    wait_drained();
    write_station('0);
    quiet = 1'b1;
    run_random(PHASE_ITEMS);
    quiet = 1'b0;

    // Phase 4: random station again.
    wait_drained();
    write_station(rand_addr());
    run_random(PHASE_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdicts.pending() != 0) begin
      $error("%0d result beats never arrived", verdicts.pending());
      verdicts.errors++;
    end
    if (verdicts.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
